// ===== design/chamfer_signed_distance_field_defines.svh =====
// Assertion macros shared by the design files.
`ifndef CHAMFER_SIGNED_DISTANCE_FIELD_DEFINES_SVH
`define CHAMFER_SIGNED_DISTANCE_FIELD_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== design/csdf_pkg.sv =====
package csdf_pkg;

  localparam int DIST_W = 18;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;
  localparam int STEP_W = 9;
  localparam logic [STEP_W-1:0] STEP_STRAIGHT = 9'd256;
  localparam logic [STEP_W-1:0] STEP_DIAG = 9'd362;

  localparam int SIDE_W = 9;
  localparam int SAT_W = 8;
  localparam int THR_W = 8;
  localparam int CFG_W = 9;
  localparam int CFG_IDX_W = 2;
  localparam int KIND_W = 2;
  localparam int IDX_W = 16;
  localparam int MASK_W = 8;
  localparam int SDF_W = 8;

  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RUN = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SIDE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THR = 2'd2;

  localparam logic [SIDE_W-1:0] SIDE_RESET = 9'd256;
  localparam logic [SAT_W-1:0] SAT_RESET = 8'd64;
  localparam logic [THR_W-1:0] THR_RESET = 8'd127;

  localparam int NUM_W = 24;
  localparam int DEN_W = 17;
  localparam int Q_W = 7;

  typedef struct packed {
    logic clr;
    logic mask_we;
    logic mask_re;
    logic dist_we;
    logic dist_re;
    logic row_load;
    logic w2_load;
    logic nb_inv;
    logic calc;
    logic fwd;
    logic enc_start;
    logic out_load;
    logic out_status;
    logic out_from_div;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic div_done;
  } sts_t;

endpackage

// ===== design/csdf_item_if.sv =====
interface csdf_item_if import csdf_pkg::*; ();
  logic valid;
  logic ready;
  logic [KIND_W-1:0] kind;
  logic [IDX_W-1:0] pixel_index;
  logic [MASK_W-1:0] mask_value;

  modport source(output valid, kind, pixel_index, mask_value, input ready);
  modport sink(input valid, kind, pixel_index, mask_value, output ready);
endinterface

// ===== design/csdf_result_if.sv =====
interface csdf_result_if import csdf_pkg::*; ();
  logic valid;
  logic ready;
  logic [SDF_W-1:0] sdf_value;
  logic status;

  modport source(output valid, sdf_value, status, input ready);
  modport sink(input valid, sdf_value, status, output ready);
endinterface

// ===== design/csdf_div.sv =====
`include "chamfer_signed_distance_field_defines.svh"
module csdf_div import csdf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic             done,
  output logic [Q_W-1:0]   quo
);

  localparam int CNT_W = $clog2(Q_W);

  logic [NUM_W-1:0] rem;
  logic [NUM_W-1:0] dsh;
  logic [CNT_W-1:0] cnt;
  logic             fits;

  assign fits = rem >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= busy && !start && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
        cnt <= CNT_W'(Q_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num;
      dsh <= NUM_W'({den, {(Q_W-1){1'b0}}});
      quo <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= rem - dsh;
      end
      quo <= {quo[Q_W-2:0], fits};
      dsh <= dsh >> 1;
    end
  end

  `ASSERT_NEXT(a_start_busy, clk, rst, start, busy)

endmodule

// ===== design/csdf_ctrl.sv =====
`include "chamfer_signed_distance_field_defines.svh"
module csdf_ctrl import csdf_pkg::*; #(
  parameter int MAX_SIDE = 256,
  localparam int AW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE * MAX_SIDE) : 1
) (
  input  logic              clk,
  input  logic              rst,
  csdf_item_if.sink         items,
  input  logic [SIDE_W-1:0] side,
  input  sts_t              sts,
  output cmd_t              cmd,
  output logic [AW-1:0]     addr
);

  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int CW = $clog2(MAX_SIDE + 1);

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_ROW   = 10'b0000000100,
    S_ROWW  = 10'b0000001000,
    S_PA    = 10'b0000010000,
    S_PB    = 10'b0000100000,
    S_PC    = 10'b0001000000,
    S_RDW   = 10'b0010000000,
    S_DIV   = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t state, state_next;
  logic [CW-1:0] x, y;
  logic [AW-1:0] i;
  logic fwd;

  logic [CW-1:0] n_c;
  logic [AW-1:0] n_a;
  logic [2*SIDE_W-1:0] nn;
  logic idx_ok, accept, x_more, y_more, row_ok, diag_ok;
  logic [AW-1:0] addr_row, addr_diag;

  assign n_c = CW'(side);
  assign n_a = AW'(side);
  assign nn = {{SIDE_W{1'b0}}, side} * {{SIDE_W{1'b0}}, side};
  assign idx_ok = {{(2*SIDE_W-IDX_W){1'b0}}, items.pixel_index} < nn;
  assign accept = items.valid && items.ready;
  assign x_more = (x + 1'b1) < n_c;
  assign y_more = (y + 1'b1) < n_c;
  assign row_ok = fwd ? (y != '0) : y_more;
  assign diag_ok = fwd ? ((y != '0) && x_more) : (y_more && (x != '0));
  assign addr_row = fwd ? (i - n_a) : (i + n_a);
  assign addr_diag = fwd ? (i - n_a + 1'b1) : (i + n_a - 1'b1);

  always_comb begin
    cmd = '0;
    cmd.fwd = fwd;
    state_next = state;
    addr = i;
    items.ready = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        cmd.dist_we = 1'b1;
        if (i == AW'(DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        items.ready = sts.out_free;
        addr = AW'(items.pixel_index);
        if (accept) begin
          case (items.kind)
            KIND_WRITE: begin
              cmd.mask_we = idx_ok;
              cmd.out_load = 1'b1;
              cmd.out_status = !idx_ok;
            end
            KIND_RUN: begin
              state_next = (side == '0) ? S_DONE : S_ROW;
            end
            KIND_READ: begin
              if (idx_ok) begin
                cmd.dist_re = 1'b1;
                state_next = S_RDW;
              end else begin
                cmd.out_load = 1'b1;
                cmd.out_status = 1'b1;
              end
            end
            default: begin
              cmd.out_load = 1'b1;
            end
          endcase
        end
      end
      S_ROW: begin
        addr = addr_row;
        cmd.dist_re = row_ok;
        state_next = S_ROWW;
      end
      S_ROWW: begin
        cmd.row_load = 1'b1;
        cmd.nb_inv = !row_ok;
        state_next = S_PA;
      end
      S_PA: begin
        addr = addr_diag;
        cmd.dist_re = diag_ok;
        state_next = S_PB;
      end
      S_PB: begin
        cmd.w2_load = 1'b1;
        cmd.nb_inv = !diag_ok;
        cmd.dist_re = 1'b1;
        cmd.mask_re = fwd;
        state_next = S_PC;
      end
      S_PC: begin
        cmd.calc = 1'b1;
        cmd.dist_we = 1'b1;
        if (fwd) begin
          state_next = x_more ? S_PA : S_ROW;
        end else if (x != '0) begin
          state_next = S_PA;
        end else if (y != '0) begin
          state_next = S_ROW;
        end else begin
          state_next = S_DONE;
        end
      end
      S_RDW: begin
        cmd.enc_start = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.out_load = 1'b1;
          cmd.out_from_div = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_DONE: begin
        cmd.out_load = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      i <= '0;
      x <= '0;
      y <= '0;
      fwd <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        S_CLEAR: begin
          i <= i + 1'b1;
        end
        S_IDLE: begin
          if (accept && (items.kind == KIND_RUN)) begin
            i <= '0;
            x <= '0;
            y <= '0;
            fwd <= 1'b1;
          end
        end
        S_PC: begin
          if (fwd) begin
            if (x_more) begin
              x <= x + 1'b1;
              i <= i + 1'b1;
            end else if (y_more) begin
              x <= '0;
              y <= y + 1'b1;
              i <= i + 1'b1;
            end else begin
              fwd <= 1'b0;
            end
          end else if (x != '0) begin
            x <= x - 1'b1;
            i <= i - 1'b1;
          end else if (y != '0) begin
            x <= n_c - 1'b1;
            y <= y - 1'b1;
            i <= i - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  `ASSERT_IMPLIES(a_ready_idle, clk, rst, items.ready, state == S_IDLE)
  `ASSERT_NEXT(a_read_div, clk, rst, state == S_RDW, state == S_DIV)

endmodule

// ===== design/csdf_dp.sv =====
`include "chamfer_signed_distance_field_defines.svh"
module csdf_dp import csdf_pkg::*; #(
  parameter int MAX_SIDE = 256,
  localparam int AW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE * MAX_SIDE) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  input  logic [AW-1:0]     addr,
  input  logic [MASK_W-1:0] mask_value,
  input  logic [THR_W-1:0]  threshold,
  input  logic [SAT_W-1:0]  saturation,
  output sts_t              sts,
  csdf_result_if.source     results
);

  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int PW = 2 * DIST_W;

  function automatic logic [DIST_W-1:0] sat_add(logic [DIST_W-1:0] a, logic [STEP_W-1:0] c);
    logic [DIST_W:0] s;
    s = {1'b0, a} + (DIST_W + 1)'(c);
    return s[DIST_W] ? DIST_MAX : s[DIST_W-1:0];
  endfunction

  function automatic logic [DIST_W-1:0] min2(logic [DIST_W-1:0] a, logic [DIST_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [DIST_W-1:0] relax(logic [DIST_W-1:0] self_d,
      logic [DIST_W-1:0] left_d, logic [DIST_W-1:0] near_d,
      logic [DIST_W-1:0] diag_a, logic [DIST_W-1:0] diag_b);
    logic [DIST_W-1:0] m0, m1;
    m0 = min2(self_d, sat_add(left_d, STEP_STRAIGHT));
    m1 = min2(sat_add(near_d, STEP_STRAIGHT), sat_add(diag_a, STEP_DIAG));
    return min2(min2(m0, m1), sat_add(diag_b, STEP_DIAG));
  endfunction

  logic mask_mem [DEPTH];
  logic mask_rd;
  logic [PW-1:0] dist_mem [DEPTH];
  logic [PW-1:0] dist_rd;

  logic [PW-1:0] win0, win1, win2, left;
  logic [PW-1:0] self_val, new_val;

  logic [SAT_W-1:0] sat_eff;
  logic [15:0] s_q;
  logic in_side, inside_r;
  logic [DIST_W-1:0] d_sel;
  logic [15:0] d_cl;
  logic [NUM_W-1:0] num;
  logic div_busy, div_done;
  logic [Q_W-1:0] quo;
  logic [SDF_W-1:0] enc;

  logic out_valid;
  logic [SDF_W-1:0] out_sdf;
  logic out_status;

  always_ff @(posedge clk) begin
    if (cmd.mask_we) begin
      mask_mem[addr] <= mask_value > threshold;
    end
    if (cmd.mask_re) begin
      mask_rd <= mask_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.dist_we) begin
      dist_mem[addr] <= cmd.clr ? '0 : new_val;
    end
    if (cmd.dist_re) begin
      dist_rd <= dist_mem[addr];
    end
  end

  assign self_val = !cmd.fwd ? dist_rd :
                    (mask_rd ? {{DIST_W{1'b0}}, DIST_MAX} : {DIST_MAX, {DIST_W{1'b0}}});

  assign new_val = {
    relax(self_val[PW-1:DIST_W], left[PW-1:DIST_W], win1[PW-1:DIST_W],
          win0[PW-1:DIST_W], win2[PW-1:DIST_W]),
    relax(self_val[DIST_W-1:0], left[DIST_W-1:0], win1[DIST_W-1:0],
          win0[DIST_W-1:0], win2[DIST_W-1:0])
  };

  always_ff @(posedge clk) begin
    if (cmd.row_load) begin
      win1 <= cmd.nb_inv ? {DIST_MAX, DIST_MAX} : dist_rd;
      win0 <= {DIST_MAX, DIST_MAX};
      left <= {DIST_MAX, DIST_MAX};
    end else if (cmd.w2_load) begin
      win2 <= cmd.nb_inv ? {DIST_MAX, DIST_MAX} : dist_rd;
    end else if (cmd.calc) begin
      win0 <= win1;
      win1 <= win2;
      left <= new_val;
    end
  end

  // Encoding divides (254*D + S) by 2*S, less one on the outside, with S = sat*256.
  assign sat_eff = (saturation == '0) ? SAT_W'(1) : saturation;
  assign s_q = {sat_eff, 8'b0};
  assign in_side = dist_rd[PW-1:DIST_W] == '0;
  assign d_sel = in_side ? dist_rd[DIST_W-1:0] : dist_rd[PW-1:DIST_W];
  assign d_cl = (d_sel > {2'b0, s_q}) ? s_q : d_sel[15:0];
  assign num = ({8'b0, d_cl} << 8) - ({8'b0, d_cl} << 1) + {8'b0, s_q}
             - {{(NUM_W-1){1'b0}}, !in_side};

  always_ff @(posedge clk) begin
    if (cmd.enc_start) begin
      inside_r <= in_side;
    end
  end

  csdf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.enc_start),
    .num   (num),
    .den   ({s_q, 1'b0}),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (quo)
  );

  assign enc = inside_r ? (8'd128 + {1'b0, quo}) : (8'd128 - {1'b0, quo});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_sdf <= cmd.out_from_div ? enc : '0;
      out_status <= cmd.out_status;
    end
  end

  assign results.valid = out_valid;
  assign results.sdf_value = out_sdf;
  assign results.status = out_status;
  assign sts.out_free = !out_valid || results.ready;
  assign sts.div_done = div_done;

  `ASSERT_IMPLIES(a_calc_sign, clk, rst, cmd.calc,
                  (new_val[PW-1:DIST_W] == '0) || (new_val[DIST_W-1:0] == '0))
  `ASSERT_IMPLIES(a_load_free, clk, rst, cmd.out_load, sts.out_free)
  `ASSERT_IMPLIES(a_div_idle, clk, rst, cmd.enc_start, !div_busy)

endmodule

// ===== design/chamfer_signed_distance_field.sv =====
// Channel    Dir   Payload                          Transfer when
// items      in    kind, pixel_index, mask_value    valid and ready high
// results    out   sdf_value, status                valid and ready high
// cfg        in    cfg_index, cfg_data              cfg_write high
//
// After reset a clearing pass zeroes all MAX_SIDE*MAX_SIDE words of the distance memory.
// Writes, unknown kinds and out-of-range items are answered from the idle state and can follow back to back.
// A read waits for the memory read and the seven-step quotient of the encoding divider.
// A run makes a forward and a backward pass: each row opens with S_ROW and S_ROWW, each pixel takes S_PA, S_PB, S_PC.
// A stalled result holds its register, and no new item is taken until it leaves.
`include "chamfer_signed_distance_field_defines.svh"
module chamfer_signed_distance_field import csdf_pkg::*; #(
  parameter int MAX_SIDE = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  csdf_item_if.sink            items,
  csdf_result_if.source        results,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int AW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE * MAX_SIDE) : 1;

  logic [SIDE_W-1:0] side_cfg;
  logic [SAT_W-1:0]  sat_cfg;
  logic [THR_W-1:0]  thr_cfg;
  logic [SIDE_W-1:0] side;
  cmd_t cmd;
  sts_t sts;
  logic [AW-1:0] addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      side_cfg <= SIDE_RESET;
      sat_cfg <= SAT_RESET;
      thr_cfg <= THR_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_SIDE: side_cfg <= cfg_data;
        CFG_SAT:  sat_cfg <= cfg_data[SAT_W-1:0];
        CFG_THR:  thr_cfg <= cfg_data[THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign side = (int'(side_cfg) > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : side_cfg;

  csdf_ctrl #(.MAX_SIDE(MAX_SIDE)) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .items (items),
    .side  (side),
    .sts   (sts),
    .cmd   (cmd),
    .addr  (addr)
  );

  csdf_dp #(.MAX_SIDE(MAX_SIDE)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .addr       (addr),
    .mask_value (items.mask_value),
    .threshold  (thr_cfg),
    .saturation (sat_cfg),
    .sts        (sts),
    .results    (results)
  );

endmodule

// ===== sim/chamfer_signed_distance_field_tb.sv =====
module chamfer_signed_distance_field_tb import csdf_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPIX = 65536;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int DIST_SAT = 262143;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0] pixel_index;
    logic [MASK_W-1:0] mask_value;
  } pixel_op_t;

  typedef struct packed {
    logic [SDF_W-1:0] sdf_value;
    logic status;
  } sdf_reply_t;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  csdf_item_if items ();
  csdf_result_if results ();

  chamfer_signed_distance_field uut (
    .clk(clk),
    .rst(rst),
    .items(items),
    .results(results),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  pixel_op_t pending_ops[$];
  sdf_reply_t expected_replies[$];

  bit mask_bits[NPIX];
  int unsigned to_inside[NPIX];
  int unsigned to_outside[NPIX];
  int unsigned side_reg;
  int unsigned sat_reg;
  int unsigned thr_reg;
  int unsigned covered;
  bit throttle;
  bit op_taken;
  int errors;
  int cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned active_side();
    return side_reg > 256 ? 256 : side_reg;
  endfunction

  function automatic int unsigned relaxed(int unsigned from_d, int unsigned cost,
                                          int unsigned at_d);
    int unsigned v;
    v = from_d + cost;
    if (v > DIST_SAT) v = DIST_SAT;
    return v < at_d ? v : at_d;
  endfunction

  task automatic relax_pair(int unsigned at, int unsigned from, int unsigned cost);
    to_inside[at] = relaxed(to_inside[from], cost, to_inside[at]);
    to_outside[at] = relaxed(to_outside[from], cost, to_outside[at]);
  endtask

  task automatic chamfer_transform();
    int unsigned n;
    int unsigned i;
    n = active_side();
    for (int unsigned p = 0; p < n * n; p++) begin
      to_inside[p] = mask_bits[p] ? 0 : DIST_SAT;
      to_outside[p] = mask_bits[p] ? DIST_SAT : 0;
    end
    for (int y = 0; y < n; y++) begin
      for (int x = 0; x < n; x++) begin
        i = y * n + x;
        if (x > 0) relax_pair(i, i - 1, 256);
        if (y > 0) relax_pair(i, i - n, 256);
        if (x > 0 && y > 0) relax_pair(i, i - n - 1, 362);
        if (x + 1 < n && y > 0) relax_pair(i, i - n + 1, 362);
      end
    end
    for (int y = n - 1; y >= 0; y--) begin
      for (int x = n - 1; x >= 0; x--) begin
        i = y * n + x;
        if (x + 1 < n) relax_pair(i, i + 1, 256);
        if (y + 1 < n) relax_pair(i, i + n, 256);
        if (x + 1 < n && y + 1 < n) relax_pair(i, i + n + 1, 362);
        if (x > 0 && y + 1 < n) relax_pair(i, i + n - 1, 362);
      end
    end
  endtask

  function automatic logic [SDF_W-1:0] encoded_distance(int unsigned i);
    int unsigned s;
    int unsigned d;
    s = (sat_reg == 0 ? 1 : sat_reg) * 256;
    if (to_inside[i] == 0) begin
      d = to_outside[i] > s ? s : to_outside[i];
      return SDF_W'(128 + (254 * d + s) / (2 * s));
    end
    d = to_inside[i] > s ? s : to_inside[i];
    return SDF_W'(128 - (254 * d + s - 1) / (2 * s));
  endfunction

  task automatic predict_reply(pixel_op_t op);
    sdf_reply_t r;
    int unsigned n;
    bit in_range;
    n = active_side();
    in_range = op.pixel_index < n * n;
    r = '0;
    case (op.kind)
      KIND_WRITE: begin
        if (in_range) mask_bits[op.pixel_index] = op.mask_value > thr_reg;
        else r.status = 1'b1;
      end
      KIND_RUN: chamfer_transform();
      KIND_READ: begin
        if (in_range) r.sdf_value = encoded_distance(op.pixel_index);
        else r.status = 1'b1;
      end
      default: ;
    endcase
    expected_replies.push_back(r);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    op_taken = !rst && items.valid && items.ready;
    if (op_taken) begin
      predict_reply('{items.kind, items.pixel_index, items.mask_value});
    end
    if (!rst && results.valid && results.ready) begin
      if (expected_replies.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected result: sdf %0d status %0d",
                                   results.sdf_value, results.status);
      end else begin
        sdf_reply_t e;
        e = expected_replies.pop_front();
        if (e.sdf_value !== results.sdf_value || e.status !== results.status) begin
          errors++;
          if (errors <= 10) $display("Mismatch: expected sdf %0d status %0d, got sdf %0d status %0d",
                                     e.sdf_value, e.status, results.sdf_value, results.status);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      items.valid <= 1'b0;
      results.ready <= 1'b0;
    end else begin
      results.ready <= !(throttle && $urandom_range(99) < 35);
      if (!items.valid || op_taken) begin
        if (pending_ops.size() > 0 && !(throttle && $urandom_range(99) < 35)) begin
          pixel_op_t op;
          op = pending_ops.pop_front();
          items.valid <= 1'b1;
          items.kind <= op.kind;
          items.pixel_index <= op.pixel_index;
          items.mask_value <= op.mask_value;
        end else begin
          items.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic queue_op(logic [KIND_W-1:0] k, int unsigned idx, int unsigned mv);
    pending_ops.push_back('{k, idx[IDX_W-1:0], mv[MASK_W-1:0]});
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_W-1:0];
    case (idx)
      CFG_SIDE: side_reg = value & 9'h1FF;
      CFG_SAT: sat_reg = value & 8'hFF;
      CFG_THR: thr_reg = value & 8'hFF;
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_ops.size() != 0 || items.valid || expected_replies.size() != 0);
    repeat (16) @(negedge clk);
  endtask

  function automatic int unsigned random_mask();
    case ($urandom_range(3))
      0: return 0;
      1: return 255;
      default: return $urandom_range(255);
    endcase
  endfunction

  task automatic run_phase(int unsigned side, int unsigned sat, int unsigned thr, bit noisy,
                           bit directed);
    int unsigned n;
    int unsigned pick;
    int unsigned lim;
    write_register(CFG_SIDE, side);
    write_register(CFG_SAT, sat);
    write_register(CFG_THR, thr);
    throttle = noisy;
    n = active_side();
    if (n <= 16) begin
      for (int unsigned p = 0; p < n * n; p++) queue_op(KIND_WRITE, p, random_mask());
      queue_op(KIND_RUN, $urandom, $urandom);
      if (n * n > covered) covered = n * n;
    end
    if (directed) begin
      queue_op(KIND_WRITE, n * n, 255);
      queue_op(KIND_WRITE, 65535, 0);
      queue_op(KIND_READ, 65535, 0);
      queue_op(KIND_UNUSED, 0, 255);
      queue_op(KIND_UNUSED, 65535, 0);
      queue_op(KIND_READ, 0, 0);
      queue_op(KIND_READ, n * n - 1, 0);
      queue_op(KIND_WRITE, 0, thr);
      queue_op(KIND_WRITE, 1, thr + 1);
      queue_op(KIND_READ, 0, 0);
      queue_op(KIND_RUN, 0, 0);
      queue_op(KIND_READ, 0, 0);
      queue_op(KIND_READ, 1, 0);
    end
    lim = covered < n * n ? covered : n * n;
    for (int k = 0; k < 60; k++) begin
      pick = $urandom_range(99);
      if (n == 0 || (pick >= 80 && pick < 90 && n < 256)) begin
        queue_op($urandom_range(1) ? KIND_READ : KIND_WRITE,
                 $urandom_range(65535, n * n), $urandom);
      end else if (pick < 30) begin
        queue_op(KIND_WRITE, $urandom_range(n * n - 1), random_mask());
      end else if (pick < 40 && n <= 16) begin
        queue_op(KIND_RUN, $urandom, $urandom);
      end else if (pick < 80 && lim > 0) begin
        queue_op(KIND_READ, $urandom_range(lim - 1), $urandom);
      end else begin
        queue_op(KIND_UNUSED, $urandom, $urandom);
      end
    end
    wait_idle();
  endtask

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = CFG_SIDE;
    cfg_data = '0;
    items.valid = 1'b0;
    items.kind = KIND_WRITE;
    items.pixel_index = '0;
    items.mask_value = '0;
    results.ready = 1'b0;
    side_reg = SIDE_RESET;
    sat_reg = SAT_RESET;
    thr_reg = THR_RESET;
    covered = 0;
    throttle = 1'b1;
    errors = 0;
    cycles = 0;
    op_taken = 1'b0;
    for (int p = 0; p < NPIX; p++) begin
      mask_bits[p] = 1'b0;
      to_inside[p] = 0;
      to_outside[p] = 0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    run_phase(5, 64, 127, 1'b1, 1'b1);
    run_phase(1, 1, 0, 1'b1, 1'b0);
    run_phase(16, 255, 254, 1'b0, 1'b0);
    run_phase(3, 0, 255, 1'b1, 1'b0);
    run_phase(0, 10, 100, 1'b1, 1'b0);
    run_phase(8, 2, 127, 1'b1, 1'b0);
    run_phase(511, 200, 50, 1'b1, 1'b0);
    run_phase(12, 37, 200, 1'b1, 1'b0);
    run_phase(256, 64, 127, 1'b1, 1'b0);
    run_phase(2, 1, 0, 1'b1, 1'b0);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

// ===== chamfer_signed_distance_field.f =====
+incdir+design
design/csdf_pkg.sv
design/csdf_item_if.sv
design/csdf_result_if.sv
design/csdf_div.sv
design/csdf_ctrl.sv
design/csdf_dp.sv
design/chamfer_signed_distance_field.sv
sim/chamfer_signed_distance_field_tb.sv
